>>> rtl/core/adc_scan_pkg.sv
// types and constants shared by the adc scan oversample report core
// no dependencies
package adc_scan_pkg;

  localparam logic [1:0] OP_CONVERSION = 2'd0;
  localparam logic [1:0] OP_POLL       = 2'd1;
  localparam logic [1:0] OP_WRITE      = 2'd2;
  localparam logic [1:0] OP_READ       = 2'd3;

  localparam logic CFG_CHANNEL_ENABLE   = 1'b0;
  localparam logic CFG_REFERENCE_SELECT = 1'b1;

  localparam logic [7:0] MUX_GROUND      = 8'h0F;
  localparam logic [7:0] COUNT_SUM_START = 8'h10;
  localparam logic [7:0] COUNT_SELECT    = 8'hF0;
  localparam logic [7:0] COUNT_RESTART   = 8'hFF;
  localparam logic [7:0] POS_DUMMY       = 8'hFF;

  localparam int CFG_DATA_W = 8;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  sample;
    logic [2:0]  channel;
    logic [15:0] write_value;
  } item_t;

  typedef struct packed {
    logic [7:0]  mux_select;
    logic        converter_running;
    logic        changed;
    logic [15:0] read_value;
  } result_t;

endpackage

>>> rtl/core/adc_scan_oversample_report_core.sv
// adc channel scanner with 16x oversampling and change reporting
// depends on adc_scan_pkg
//
// Each transfer on the item channel gives exactly one transfer on the result
// channel. The block works on one item at a time under a small sequencer that
// drives one shared 17-bit adder (sample sum, sample count, scan position,
// poll timer and rounding all go through it). A write or read runs exec then
// done; a conversion exec, count, done (exec, done while the converter is
// stopped); a poll exec, done, with round between when its timer expires. A
// channel's last sample adds store and one search step per position advanced
// plus one on an enabled channel; past the last channel the scan stops.
// The result sits in an output register, so the block takes the next item
// in the cycle the result is taken.
module adc_scan_oversample_report_core #(
  parameter int CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic                                 cfg_index,
  input  logic [adc_scan_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  adc_scan_pkg::item_t                  item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output adc_scan_pkg::result_t                result
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [7:0] CH_LIMIT = 8'(CHANNELS);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EXEC   = 7'b0000010,
    ST_STORE  = 7'b0000100,
    ST_SEARCH = 7'b0001000,
    ST_COUNT  = 7'b0010000,
    ST_ROUND  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0] channel_enable;
  logic [1:0] reference_select;

  adc_scan_pkg::item_t cur;
  logic        changed;
  logic [15:0] read_value;

  logic [7:0]  scan_position;
  logic [7:0]  sample_count;
  logic [15:0] sample_sum;
  logic [7:0]  current_mux;
  logic        converter_on;
  logic [15:0] averaged_value [CHANNELS];
  logic [15:0] reported_value [CHANNELS];
  logic [7:0]  poll_countdown [CHANNELS];

  logic [15:0] alu_a;
  logic [15:0] alu_b;
  logic [16:0] alu_y;
  logic [15:0] rounded;

  logic             ch_ok;
  logic [IDX_W-1:0] ch_idx;
  logic [IDX_W-1:0] pos_idx;
  logic             pos_in_range;
  logic             pos_enabled;
  logic [7:0]       pos_mux;
  logic             item_taken;
  logic             result_taken;

  assign ch_ok        = 8'(cur.channel) < CH_LIMIT;
  assign ch_idx       = IDX_W'(cur.channel);
  assign pos_idx      = IDX_W'(scan_position);
  assign pos_in_range = scan_position < CH_LIMIT;
  assign pos_enabled  = pos_in_range && (scan_position < 8'd8) &&
                        channel_enable[scan_position[2:0]];
  assign pos_mux      = pos_enabled ?
                        ({reference_select, 6'b0} | 8'(scan_position[3:0])) :
                        adc_scan_pkg::MUX_GROUND;

  assign item_stall   = !((state == ST_IDLE) && (!result_valid || !result_stall));
  assign item_taken   = item_valid && !item_stall;
  assign result_taken = result_valid && !result_stall;

  // shared adder
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state)
      ST_EXEC: begin
        if (cur.op == adc_scan_pkg::OP_CONVERSION) begin
          alu_a = sample_sum;
          alu_b = 16'(cur.sample);
        end else if (cur.op == adc_scan_pkg::OP_POLL) begin
          alu_a = 16'(poll_countdown[ch_idx]);
          alu_b = 16'hFFFF;
        end
      end
      ST_STORE, ST_SEARCH: begin
        alu_a = 16'(scan_position);
        alu_b = 16'd1;
      end
      ST_COUNT: begin
        alu_a = 16'(sample_count);
        alu_b = 16'hFFFF;
      end
      ST_ROUND: begin
        alu_a = averaged_value[ch_idx];
        alu_b = 16'd8;
      end
      default: begin
      end
    endcase
  end

  assign alu_y   = 17'(alu_a) + 17'(alu_b);
  assign rounded = 16'(alu_y[16:4]);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable   <= '0;
      reference_select <= 2'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        adc_scan_pkg::CFG_CHANNEL_ENABLE:   channel_enable   <= cfg_data[7:0];
        adc_scan_pkg::CFG_REFERENCE_SELECT: reference_select <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_valid  <= 1'b0;
      changed       <= 1'b0;
      read_value    <= '0;
      scan_position <= '0;
      sample_count  <= adc_scan_pkg::COUNT_RESTART;
      sample_sum    <= '0;
      current_mux   <= adc_scan_pkg::MUX_GROUND;
      converter_on  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        averaged_value[i] <= '0;
        reported_value[i] <= '0;
        poll_countdown[i] <= '0;
      end
    end else begin
      if (result_taken) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_taken) begin
            cur        <= item;
            changed    <= 1'b0;
            read_value <= '0;
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (cur.op)
            adc_scan_pkg::OP_CONVERSION: begin
              if (!converter_on) begin
                state <= ST_DONE;
              end else if (sample_count < adc_scan_pkg::COUNT_SUM_START) begin
                sample_sum <= alu_y[15:0];
                state      <= (sample_count == '0) ? ST_STORE : ST_COUNT;
              end else begin
                if (sample_count == adc_scan_pkg::COUNT_SELECT) begin
                  sample_sum  <= '0;
                  current_mux <= pos_mux;
                end
                state <= ST_COUNT;
              end
            end
            adc_scan_pkg::OP_POLL: begin
              if (!converter_on) begin
                scan_position <= adc_scan_pkg::POS_DUMMY;
                sample_count  <= adc_scan_pkg::COUNT_RESTART;
                converter_on  <= 1'b1;
              end
              if (ch_ok) begin
                poll_countdown[ch_idx] <= alu_y[7:0];
              end
              state <= (ch_ok && alu_y[7:0] == '0) ? ST_ROUND : ST_DONE;
            end
            adc_scan_pkg::OP_WRITE: begin
              if (ch_ok) begin
                reported_value[ch_idx] <= cur.write_value;
                poll_countdown[ch_idx] <= 8'd1;
              end
              state <= ST_DONE;
            end
            adc_scan_pkg::OP_READ: begin
              if (ch_ok) begin
                read_value <= reported_value[ch_idx];
              end
              state <= ST_DONE;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_STORE: begin
          if (current_mux != adc_scan_pkg::MUX_GROUND && pos_in_range) begin
            averaged_value[pos_idx] <= sample_sum;
          end
          scan_position <= alu_y[7:0];
          state         <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (!pos_in_range) begin
            converter_on <= 1'b0;
            state        <= ST_DONE;
          end else if (pos_enabled) begin
            state <= ST_COUNT;
          end else begin
            scan_position <= alu_y[7:0];
          end
        end
        ST_COUNT: begin
          sample_count <= alu_y[7:0];
          state        <= ST_DONE;
        end
        ST_ROUND: begin
          if (reported_value[ch_idx] != rounded) begin
            reported_value[ch_idx] <= rounded;
            changed                <= 1'b1;
            read_value             <= rounded;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          result_valid             <= 1'b1;
          result.mux_select        <= current_mux;
          result.converter_running <= converter_on;
          result.changed           <= changed;
          result.read_value        <= read_value;
          state                    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside of done step");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> item_stall)
    else $error("item taken while busy");

  a_search_stop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && !pos_in_range) |=> !converter_on)
    else $error("converter still running after last channel");

  a_store_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |-> (sample_count == '0 && converter_on))
    else $error("average stored away from count zero");

  a_round_after_poll: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> ($past(state) == ST_EXEC && cur.op == adc_scan_pkg::OP_POLL))
    else $error("rounding step without poll");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for adc_scan_oversample_report_core, uses adc_scan_pkg
// a scoreboard class mirrors the scanner state and checks every result transfer
// in order, while directed and random scan phases run under random gaps and stalls
module testbench;

  localparam int CHANNELS = 8;
  localparam int LIMIT = 400000;

  class scan_tracker;
    logic [7:0]  chan_en;
    logic [1:0]  ref_sel;
    logic [7:0]  scan_pos;
    logic [7:0]  count;
    logic [15:0] sum;
    logic [7:0]  mux;
    logic        conv_on;
    logic [15:0] avg [CHANNELS];
    logic [15:0] reported [CHANNELS];
    logic [7:0]  countdown [CHANNELS];
    adc_scan_pkg::result_t due_results[$];
    int          mismatches;

    function new();
      chan_en = 8'h00;
      ref_sel = 2'd1;
      scan_pos = 8'h00;
      count = adc_scan_pkg::COUNT_RESTART;
      sum = 16'h0000;
      mux = adc_scan_pkg::MUX_GROUND;
      conv_on = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        avg[i] = 16'h0000;
        reported[i] = 16'h0000;
        countdown[i] = 8'h00;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [adc_scan_pkg::CFG_DATA_W-1:0] data);
      if (idx == adc_scan_pkg::CFG_CHANNEL_ENABLE) begin
        chan_en = data[7:0];
      end else begin
        ref_sel = data[1:0];
      end
    endfunction

    // one conversion while the scan runs
    function void take_sample(logic [9:0] smp);
      if (!conv_on) return;
      if (count < adc_scan_pkg::COUNT_SUM_START) begin
        sum = sum + {6'b0, smp};
        if (count == 8'h00) begin
          if (mux != adc_scan_pkg::MUX_GROUND && scan_pos < CHANNELS)
            avg[scan_pos[2:0]] = sum;
          do begin
            scan_pos = scan_pos + 8'd1;
          end while (scan_pos < CHANNELS && !chan_en[scan_pos[2:0]]);
          if (scan_pos >= CHANNELS) begin
            conv_on = 1'b0;
            return;
          end
        end
      end else if (count == adc_scan_pkg::COUNT_SELECT) begin
        sum = 16'h0000;
        mux = (scan_pos < CHANNELS && chan_en[scan_pos[2:0]]) ?
              {ref_sel, 3'b000, scan_pos[2:0]} : adc_scan_pkg::MUX_GROUND;
      end
      count = count - 8'd1;
    endfunction

    function void accept_item(adc_scan_pkg::item_t it);
      adc_scan_pkg::result_t r;
      logic [16:0] rnd;
      logic [15:0] act;
      r = '0;
      case (it.op)
        adc_scan_pkg::OP_CONVERSION: take_sample(it.sample);
        adc_scan_pkg::OP_POLL: begin
          if (!conv_on) begin
            scan_pos = adc_scan_pkg::POS_DUMMY;
            count = adc_scan_pkg::COUNT_RESTART;
            conv_on = 1'b1;
          end
          countdown[it.channel] = countdown[it.channel] - 8'd1;
          if (countdown[it.channel] == 8'h00) begin
            rnd = {1'b0, avg[it.channel]} + 17'd8;
            act = {3'b000, rnd[16:4]};
            if (reported[it.channel] != act) begin
              reported[it.channel] = act;
              r.changed = 1'b1;
              r.read_value = act;
            end
          end
        end
        adc_scan_pkg::OP_WRITE: begin
          reported[it.channel] = it.write_value;
          countdown[it.channel] = 8'd1;
        end
        default: r.read_value = reported[it.channel];
      endcase
      r.mux_select = mux;
      r.converter_running = conv_on;
      due_results.push_back(r);
    endfunction

    function void check_result(adc_scan_pkg::result_t got);
      adc_scan_pkg::result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result transfer with nothing pending: mux %h run %b chg %b val %h",
                   got.mux_select, got.converter_running, got.changed, got.read_value);
        return;
      end
      want = due_results.pop_front();
      if (got.mux_select !== want.mux_select ||
          got.converter_running !== want.converter_running ||
          got.changed !== want.changed ||
          got.read_value !== want.read_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected mux %h run %b chg %b val %h, ",
                    "got mux %h run %b chg %b val %h"},
                   want.mux_select, want.converter_running, want.changed, want.read_value,
                   got.mux_select, got.converter_running, got.changed, got.read_value);
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic                                cfg_index = 1'b0;
  logic [adc_scan_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                                item_valid = 1'b0;
  logic                                item_stall;
  adc_scan_pkg::item_t                 item = '0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  adc_scan_pkg::result_t               result;
  bit                                  quiet = 1'b0;

  scan_tracker sb = new();

  adc_scan_oversample_report_core #(.CHANNELS(CHANNELS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= !quiet && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic adc_scan_pkg::item_t mk(logic [1:0] op, logic [9:0] smp,
                                             logic [2:0] ch, logic [15:0] wv);
    adc_scan_pkg::item_t it;
    it.op = op;
    it.sample = smp;
    it.channel = ch;
    it.write_value = wv;
    return it;
  endfunction

  function automatic adc_scan_pkg::item_t random_item();
    adc_scan_pkg::item_t it;
    int    pick;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) begin
      it.sample = $urandom_range(1) ? 10'h3FF : 10'h000;
    end else begin
      it.sample = 10'($urandom_range(1023));
    end
    it.channel = 3'($urandom_range(7));
    it.write_value = 16'($urandom_range(65535));
    if (!sb.conv_on) begin
      it.op = (pick < 60) ? adc_scan_pkg::OP_POLL :
              (pick < 75) ? adc_scan_pkg::OP_WRITE :
              (pick < 90) ? adc_scan_pkg::OP_READ : adc_scan_pkg::OP_CONVERSION;
    end else begin
      it.op = (pick < 85) ? adc_scan_pkg::OP_CONVERSION :
              (pick < 90) ? adc_scan_pkg::OP_POLL :
              (pick < 95) ? adc_scan_pkg::OP_WRITE : adc_scan_pkg::OP_READ;
    end
    return it;
  endfunction

  task automatic send_item(input adc_scan_pkg::item_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 40) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.accept_item(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] en, input logic [1:0] rsel);
    cfg_write <= 1'b1;
    cfg_index <= adc_scan_pkg::CFG_CHANNEL_ENABLE;
    cfg_data <= en;
    @(posedge clk);
    sb.write_reg(adc_scan_pkg::CFG_CHANNEL_ENABLE, en);
    cfg_index <= adc_scan_pkg::CFG_REFERENCE_SELECT;
    cfg_data <= {6'b0, rsel};
    @(posedge clk);
    sb.write_reg(adc_scan_pkg::CFG_REFERENCE_SELECT, {6'b0, rsel});
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // random items until the budget is used or, if asked, until the scan stops
  task automatic run_phase(input logic [7:0] en, input logic [1:0] rsel,
                           input int budget, input bit until_stop, input bit calm);
    adc_scan_pkg::item_t it;
    int    n;
    bit    started;
    n = 0;
    started = 1'b0;
    set_config(en, rsel);
    while (n < budget) begin
      quiet = calm && n >= 150 && n < 350;
      it = random_item();
      if (!(it.op == adc_scan_pkg::OP_CONVERSION && !sb.conv_on)) n++;
      send_item(it);
      if (sb.conv_on) started = 1'b1;
      if (until_stop && started && !sb.conv_on) break;
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset reads, stopped conversion, write/poll/read, timer wrap
    set_config(8'h81, 2'd2);
    send_item(mk(adc_scan_pkg::OP_READ, 10'h000, 3'd0, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_READ, 10'h3FF, 3'd7, 16'hFFFF));
    send_item(mk(adc_scan_pkg::OP_CONVERSION, 10'h3FF, 3'd0, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_WRITE, 10'h000, 3'd3, 16'hFFFF));
    send_item(mk(adc_scan_pkg::OP_READ, 10'h000, 3'd3, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_POLL, 10'h000, 3'd3, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_POLL, 10'h000, 3'd3, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_WRITE, 10'h3FF, 3'd0, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_POLL, 10'h000, 3'd0, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_WRITE, 10'h000, 3'd5, 16'hA5A5));
    send_item(mk(adc_scan_pkg::OP_READ, 10'h000, 3'd5, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_POLL, 10'h000, 3'd7, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_CONVERSION, 10'h000, 3'd0, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_CONVERSION, 10'h3FF, 3'd7, 16'hFFFF));
    send_item(mk(adc_scan_pkg::OP_CONVERSION, 10'h2AA, 3'd2, 16'h5555));
    send_item(mk(adc_scan_pkg::OP_CONVERSION, 10'h155, 3'd5, 16'hAAAA));
    send_item(mk(adc_scan_pkg::OP_WRITE, 10'h000, 3'd6, 16'h5A5A));
    send_item(mk(adc_scan_pkg::OP_POLL, 10'h000, 3'd6, 16'h0000));
    send_item(mk(adc_scan_pkg::OP_READ, 10'h000, 3'd6, 16'h0000));
    drain();

    // random scans: one channel to completion, none enabled, then all enabled
    run_phase(8'h01 << $urandom_range(7), 2'($urandom_range(3)), 800, 1'b1, 1'b1);
    run_phase(8'h00, 2'd3, 400, 1'b1, 1'b0);
    run_phase(8'hFF, 2'd0, 120, 1'b0, 1'b0);

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
